@@ design/lccp_pkg.sv @@
// Shared constants for the line-line closest points core.
// Used by lccp_div and line_line_closest_points_core; no dependencies.
package lccp_pkg;

  localparam int DIR_W    = 32;
  localparam int DIR_FRAC = 30;
  localparam int THR_W    = 62;
  localparam logic [THR_W-1:0] THR_RESET = 62'd11529215046;
  // quotient bits kept by the divider; the line parameters clamp at 2^64
  localparam int QB       = 65;

endpackage

@@ design/line_line_closest_points_core.sv @@
// Closest points between two 3D lines, fully pipelined, top level.
// Depends on lccp_pkg, lccp_div and lccp_sqrt.
//
// One line pair enters per cycle while the output is not stalled and passes
// through the front end, the divider, the point and distance stages, the
// square root and the output register. The quotient divider, one bit per
// stage, and the square root, one root bit per stage, set the latency.
// Every stage holds while the output item waits; configuration writes
// take effect on items that have not yet reached the parallel test.
module line_line_closest_points_core #(
  parameter int COORD_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_wen_i,
  input  logic [lccp_pkg::THR_W-1:0] cfg_wdata_i,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // first_point x,y,z; first_dir x,y,z; second_point x,y,z; second_dir x,y,z
  input  logic [((6*COORD_WIDTH+6*lccp_pkg::DIR_W+7)/8)*8-1:0] s_axis_tdata_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // near_first x,y,z; near_second x,y,z; gap_length
  output logic [((7*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata_o,
  // parallel_flag, saturated_flag
  output logic [1:0] m_axis_tuser_o
);

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = lccp_pkg::DIR_W;
  localparam int FR   = lccp_pkg::DIR_FRAC;
  localparam int QB   = lccp_pkg::QB;
  localparam int WW   = CW + 1;
  localparam int PW   = 2 * DW;
  localparam int SAW  = PW + 2;
  localparam int ABW  = SAW - FR;
  localparam int MW   = DW + WW;
  localparam int DEW  = MW + 2;
  localparam int EL   = DEW / 2;
  localparam int EH   = DEW - EL;
  localparam int DNW  = 2 * ABW + 1;
  localparam int DMW  = 2 * ABW;
  localparam int NW   = ABW + DEW + 1;
  localparam int KW   = QB + 1;
  localparam int KL   = KW / 2;
  localparam int KH   = KW - KL;
  localparam int OW   = DW + KW;
  localparam int OFW  = OW - FR;
  localparam int VW   = OFW + 1;
  localparam int MGW  = CW + 1;
  localparam int H    = (MGW + 1) / 2;
  localparam int HH   = MGW - H;
  localparam int SQ1  = 2 * MGW;
  localparam int SQW  = SQ1 + 2;
  localparam int RB   = CW + 2;
  localparam int OFF_D1 = 3 * CW;
  localparam int OFF_P2 = 3 * CW + 3 * DW;
  localparam int OFF_D2 = 6 * CW + 3 * DW;
  localparam int GW   = 6 * CW + 6 * DW;
  localparam int OUTW = ((7 * CW + 7) / 8) * 8;
  localparam int DSW  = GW + 3;
  localparam int QSW  = 6 * CW + 2;
  localparam logic signed [OW-1:0] RND = OW'(1) <<< (FR - 1);

  logic adv;
  logic [lccp_pkg::THR_W-1:0] thr_q;

  logic out_v_q;
  logic [OUTW-1:0] out_data_q;
  logic [1:0] out_user_q;

  assign adv             = ~out_v_q | m_axis_tready_i;
  assign s_axis_tready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= lccp_pkg::THR_RESET;
    end else if (cfg_wen_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // ---------------- stage 1: dot product terms
  logic signed [CW-1:0] ip1[3], ip2[3];
  logic signed [DW-1:0] id1[3], id2[3];
  logic signed [WW-1:0] iw0[3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ip1[i] = $signed(s_axis_tdata_i[i*CW +: CW]);
      id1[i] = $signed(s_axis_tdata_i[OFF_D1 + i*DW +: DW]);
      ip2[i] = $signed(s_axis_tdata_i[OFF_P2 + i*CW +: CW]);
      id2[i] = $signed(s_axis_tdata_i[OFF_D2 + i*DW +: DW]);
      iw0[i] = WW'(ip1[i]) - WW'(ip2[i]);
    end
  end

  logic v1_q;
  logic signed [PW-1:0] aa1_q[3], bb1_q[3], cc1_q[3];
  logic signed [MW-1:0] dd1_q[3], ee1_q[3];
  logic [GW-1:0] geo1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        aa1_q[i] <= id1[i] * id1[i];
        bb1_q[i] <= id1[i] * id2[i];
        cc1_q[i] <= id2[i] * id2[i];
        dd1_q[i] <= id1[i] * iw0[i];
        ee1_q[i] <= id2[i] * iw0[i];
      end
      geo1_q <= s_axis_tdata_i[GW-1:0];
    end
  end

  // ---------------- stage 2: dot products
  logic signed [SAW-1:0] sa, sb, sc;
  logic v2_q;
  logic signed [ABW-1:0] a2_q, b2_q, c2_q;
  logic signed [DEW-1:0] d2_q, e2_q;
  logic [GW-1:0] geo2_q;

  always_comb begin
    sa = SAW'(aa1_q[0]) + SAW'(aa1_q[1]) + SAW'(aa1_q[2]);
    sb = SAW'(bb1_q[0]) + SAW'(bb1_q[1]) + SAW'(bb1_q[2]);
    sc = SAW'(cc1_q[0]) + SAW'(cc1_q[1]) + SAW'(cc1_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a2_q   <= ABW'(sa >>> FR);
      b2_q   <= ABW'(sb >>> FR);
      c2_q   <= ABW'(sc >>> FR);
      d2_q   <= DEW'(dd1_q[0]) + DEW'(dd1_q[1]) + DEW'(dd1_q[2]);
      e2_q   <= DEW'(ee1_q[0]) + DEW'(ee1_q[1]) + DEW'(ee1_q[2]);
      geo2_q <= geo1_q;
    end
  end

  // ---------------- stage 3: products, wide operands split in halves
  logic signed [EL:0]   elo, dlo;
  logic signed [EH-1:0] ehi, dhi;

  always_comb begin
    elo = {1'b0, e2_q[EL-1:0]};
    dlo = {1'b0, d2_q[EL-1:0]};
    ehi = $signed(e2_q[DEW-1:EL]);
    dhi = $signed(d2_q[DEW-1:EL]);
  end

  logic v3_q;
  logic signed [DNW-1:0] ac3_q, bb3_q;
  logic signed [ABW+EL:0] bel3_q, cdl3_q, ael3_q, bdl3_q;
  logic signed [ABW+EH-1:0] beh3_q, cdh3_q, aeh3_q, bdh3_q;
  logic signed [ABW-1:0] c3_q;
  logic signed [DEW-1:0] e3_q;
  logic [GW-1:0] geo3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ac3_q  <= a2_q * c2_q;
      bb3_q  <= b2_q * b2_q;
      bel3_q <= b2_q * elo;
      beh3_q <= b2_q * ehi;
      cdl3_q <= c2_q * dlo;
      cdh3_q <= c2_q * dhi;
      ael3_q <= a2_q * elo;
      aeh3_q <= a2_q * ehi;
      bdl3_q <= b2_q * dlo;
      bdh3_q <= b2_q * dhi;
      c3_q   <= c2_q;
      e3_q   <= e2_q;
      geo3_q <= geo2_q;
    end
  end

  // ---------------- stage 4: denominator and numerators
  logic v4_q;
  logic signed [DNW-1:0] den4_q;
  logic signed [NW-1:0] ns4_q, nt4_q;
  logic signed [ABW-1:0] c4_q;
  logic signed [DEW-1:0] e4_q;
  logic [GW-1:0] geo4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      den4_q <= ac3_q - bb3_q;
      ns4_q  <= (NW'(beh3_q) <<< EL) + NW'(bel3_q) - (NW'(cdh3_q) <<< EL) - NW'(cdl3_q);
      nt4_q  <= (NW'(aeh3_q) <<< EL) + NW'(ael3_q) - (NW'(bdh3_q) <<< EL) - NW'(bdl3_q);
      c4_q   <= c3_q;
      e4_q   <= e3_q;
      geo4_q <= geo3_q;
    end
  end

  // ---------------- stage 5: parallel test, magnitudes and signs
  logic [DMW-1:0] dabs;
  logic           par;
  logic [NW-1:0]  nsabs, ntabs, eabs;

  always_comb begin
    dabs  = den4_q[DNW-1] ? DMW'(-den4_q) : DMW'(den4_q);
    par   = dabs <= DMW'(thr_q);
    nsabs = ns4_q[NW-1] ? NW'(-ns4_q) : NW'(ns4_q);
    ntabs = nt4_q[NW-1] ? NW'(-nt4_q) : NW'(nt4_q);
    eabs  = e4_q[DEW-1] ? NW'(-e4_q) : NW'(e4_q);
  end

  logic v5_q;
  logic [NW-1:0] ns5_q, nt5_q;
  logic [DMW-1:0] dv5_q;
  logic par5_q, sgs5_q, sgt5_q;
  logic [GW-1:0] geo5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      par5_q <= par;
      ns5_q  <= par ? '0 : nsabs;
      nt5_q  <= par ? eabs : ntabs;
      dv5_q  <= par ? DMW'($unsigned(c4_q)) : dabs;
      sgs5_q <= ns4_q[NW-1] ^ den4_q[DNW-1];
      sgt5_q <= par ? e4_q[DEW-1] : (nt4_q[NW-1] ^ den4_q[DNW-1]);
      geo5_q <= geo4_q;
    end
  end

  // ---------------- divider
  logic dv_valid;
  logic [QB-1:0] dqs, dqt;
  logic dovs, dovt, ddz;
  logic [DSW-1:0] dside;

  lccp_div #(
    .NW  (NW),
    .DMW (DMW),
    .SW  (DSW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v5_q),
    .ns_i    (ns5_q),
    .nt_i    (nt5_q),
    .dv_i    (dv5_q),
    .side_i  ({par5_q, sgs5_q, sgt5_q, geo5_q}),
    .valid_o (dv_valid),
    .qs_o    (dqs),
    .qt_o    (dqt),
    .ovs_o   (dovs),
    .ovt_o   (dovt),
    .dz_o    (ddz),
    .side_o  (dside)
  );

  // ---------------- F1: clamp and sign the line parameters
  logic [KW-1:0] ms, mt;

  always_comb begin
    ms = (dovs | (dqs[QB-1] & (|dqs[QB-2:0]))) ? KW'(1) << (QB - 1) : KW'(dqs);
    mt = (dovt | (dqt[QB-1] & (|dqt[QB-2:0]))) ? KW'(1) << (QB - 1) : KW'(dqt);
    if (ddz) begin
      ms = '0;
      mt = '0;
    end
  end

  logic f1_q;
  logic signed [KW-1:0] ks1_q, kt1_q;
  logic par1_q;
  logic [GW-1:0] geof1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ks1_q   <= dside[GW+1] ? -ms : ms;
      kt1_q   <= dside[GW] ? -mt : mt;
      par1_q  <= dside[GW+2];
      geof1_q <= dside[GW-1:0];
    end
  end

  // ---------------- F2: direction times parameter, split
  logic signed [KL:0]   ksl, ktl;
  logic signed [KH-1:0] ksh, kth;
  logic signed [DW-1:0] dir2[6];

  always_comb begin
    ksl = {1'b0, ks1_q[KL-1:0]};
    ktl = {1'b0, kt1_q[KL-1:0]};
    ksh = $signed(ks1_q[KW-1:KL]);
    kth = $signed(kt1_q[KW-1:KL]);
    for (int j = 0; j < 3; j++) begin
      dir2[j]   = $signed(geof1_q[OFF_D1 + j*DW +: DW]);
      dir2[j+3] = $signed(geof1_q[OFF_D2 + j*DW +: DW]);
    end
  end

  logic f2_q;
  logic signed [DW+KL:0] pl2_q[6];
  logic signed [DW+KH-1:0] ph2_q[6];
  logic par2_q;
  logic [GW-1:0] geof2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        pl2_q[j]   <= dir2[j] * ksl;
        ph2_q[j]   <= dir2[j] * ksh;
        pl2_q[j+3] <= dir2[j+3] * ktl;
        ph2_q[j+3] <= dir2[j+3] * kth;
      end
      par2_q  <= par1_q;
      geof2_q <= geof1_q;
    end
  end

  // ---------------- F3: offsets rounded to point scale
  logic signed [OW-1:0] full3[6];

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      full3[j] = (OW'(ph2_q[j]) <<< KL) + OW'(pl2_q[j]) + RND;
    end
  end

  logic f3_q;
  logic signed [OFW-1:0] off3_q[6];
  logic par3_q;
  logic [GW-1:0] geof3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < 6; j++) begin
        off3_q[j] <= OFW'(full3[j] >>> FR);
      end
      par3_q  <= par2_q;
      geof3_q <= geof2_q;
    end
  end

  // ---------------- F4: add to points and saturate
  logic signed [VW-1:0] v4[6];
  logic signed [CW-1:0] n4[6];
  logic                 sat4;

  always_comb begin
    sat4 = 1'b0;
    for (int j = 0; j < 3; j++) begin
      v4[j]   = VW'($signed(geof3_q[j*CW +: CW])) + VW'(off3_q[j]);
      v4[j+3] = VW'($signed(geof3_q[OFF_P2 + j*CW +: CW])) + VW'(off3_q[j+3]);
    end
    for (int j = 0; j < 6; j++) begin
      if ((&v4[j][VW-1:CW-1]) | ~(|v4[j][VW-1:CW-1])) begin
        n4[j] = v4[j][CW-1:0];
      end else begin
        sat4  = 1'b1;
        n4[j] = v4[j][VW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  logic f4_q;
  logic signed [CW-1:0] n4_q[6];
  logic par4_q, sat4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n4_q   <= n4;
      par4_q <= par3_q;
      sat4_q <= sat4;
    end
  end

  // ---------------- F5: coordinate gaps
  logic signed [MGW-1:0] df5[3];
  logic [6*CW-1:0] npk;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      df5[i] = MGW'(n4_q[i]) - MGW'(n4_q[i+3]);
    end
    for (int j = 0; j < 6; j++) begin
      npk[j*CW +: CW] = n4_q[j];
    end
  end

  logic f5_q;
  logic [MGW-1:0] mag5_q[3];
  logic [6*CW-1:0] npk5_q;
  logic par5f_q, sat5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        mag5_q[i] <= df5[i][MGW-1] ? MGW'(-df5[i]) : MGW'(df5[i]);
      end
      npk5_q  <= npk;
      par5f_q <= par4_q;
      sat5_q  <= sat4_q;
    end
  end

  // ---------------- F6: partial squares
  logic f6_q;
  logic [2*HH-1:0] hh6_q[3];
  logic [HH+H-1:0] hl6_q[3];
  logic [2*H-1:0]  ll6_q[3];
  logic [6*CW-1:0] npk6_q;
  logic par6_q, sat6_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        hh6_q[i] <= mag5_q[i][MGW-1:H] * mag5_q[i][MGW-1:H];
        hl6_q[i] <= mag5_q[i][MGW-1:H] * mag5_q[i][H-1:0];
        ll6_q[i] <= mag5_q[i][H-1:0] * mag5_q[i][H-1:0];
      end
      npk6_q <= npk5_q;
      par6_q <= par5f_q;
      sat6_q <= sat5_q;
    end
  end

  // ---------------- F7: squares
  logic f7_q;
  logic [SQ1-1:0] sq7_q[3];
  logic [6*CW-1:0] npk7_q;
  logic par7_q, sat7_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq7_q[i] <= (SQ1'(hh6_q[i]) << (2 * H)) + (SQ1'(hl6_q[i]) << (H + 1))
                    + SQ1'(ll6_q[i]);
      end
      npk7_q <= npk6_q;
      par7_q <= par6_q;
      sat7_q <= sat6_q;
    end
  end

  // ---------------- F8: sum of squares
  logic f8_q;
  logic [SQW-1:0] sum8_q;
  logic [6*CW-1:0] npk8_q;
  logic par8_q, sat8_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum8_q <= SQW'(sq7_q[0]) + SQW'(sq7_q[1]) + SQW'(sq7_q[2]);
      npk8_q <= npk7_q;
      par8_q <= par7_q;
      sat8_q <= sat7_q;
    end
  end

  // ---------------- square root and output register
  logic rt_valid;
  logic [RB-1:0] root;
  logic [QSW-1:0] rside;
  logic gclip;

  lccp_sqrt #(
    .SQW (SQW),
    .RB  (RB),
    .SW  (QSW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (f8_q),
    .sum_i   (sum8_q),
    .side_i  ({par8_q, sat8_q, npk8_q}),
    .valid_o (rt_valid),
    .root_o  (root),
    .side_o  (rside)
  );

  assign gclip = |root[RB-1:CW];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= OUTW'({gclip ? {CW{1'b1}} : root[CW-1:0], rside[6*CW-1:0]});
      out_user_q <= {rside[6*CW] | gclip, rside[6*CW+1]};
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      f1_q    <= 1'b0;
      f2_q    <= 1'b0;
      f3_q    <= 1'b0;
      f4_q    <= 1'b0;
      f5_q    <= 1'b0;
      f6_q    <= 1'b0;
      f7_q    <= 1'b0;
      f8_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      v1_q    <= s_axis_tvalid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      v5_q    <= v4_q;
      f1_q    <= dv_valid;
      f2_q    <= f1_q;
      f3_q    <= f2_q;
      f4_q    <= f3_q;
      f5_q    <= f4_q;
      f6_q    <= f5_q;
      f7_q    <= f6_q;
      f8_q    <= f7_q;
      out_v_q <= rt_valid;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

@@ design/lccp_div.sv @@
// Pipelined restoring divider with two dividends over one shared divisor.
// Depends on lccp_pkg (quotient length); one quotient bit per stage.
module lccp_div #(
  parameter int NW  = 104,
  parameter int DMW = 72,
  parameter int SW  = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [NW-1:0]  ns_i,
  input  logic [NW-1:0]  nt_i,
  input  logic [DMW-1:0] dv_i,
  input  logic [SW-1:0]  side_i,
  output logic           valid_o,
  output logic [lccp_pkg::QB-1:0] qs_o,
  output logic [lccp_pkg::QB-1:0] qt_o,
  output logic           ovs_o,
  output logic           ovt_o,
  output logic           dz_o,
  output logic [SW-1:0]  side_o
);

  localparam int QB   = lccp_pkg::QB;
  localparam int NNW  = NW + 1;
  localparam int HW   = NNW - QB;
  localparam int CMPW = (HW > DMW) ? HW : DMW;

  logic           va_q;
  logic [NNW-1:0] nsa_q, nta_q;
  logic [DMW-1:0] dva_q;
  logic [SW-1:0]  sidea_q;

  logic           v_q  [QB+1];
  logic [DMW-1:0] rs_q [QB+1];
  logic [DMW-1:0] rt_q [QB+1];
  logic [DMW-1:0] dv_q [QB+1];
  logic [QB-1:0]  ls_q [QB+1];
  logic [QB-1:0]  lt_q [QB+1];
  logic [QB-1:0]  qs_q [QB+1];
  logic [QB-1:0]  qt_q [QB+1];
  logic           os_q [QB+1];
  logic           ot_q [QB+1];
  logic           dz_q [QB+1];
  logic [SW-1:0]  sd_q [QB+1];

  // round to nearest: add half the divisor up front
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q   <= 1'b0;
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      va_q   <= valid_i;
      v_q[0] <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nsa_q   <= NNW'(ns_i) + NNW'(dv_i >> 1);
      nta_q   <= NNW'(nt_i) + NNW'(dv_i >> 1);
      dva_q   <= dv_i;
      sidea_q <= side_i;
      rs_q[0] <= DMW'(nsa_q >> QB);
      rt_q[0] <= DMW'(nta_q >> QB);
      ls_q[0] <= nsa_q[QB-1:0];
      lt_q[0] <= nta_q[QB-1:0];
      os_q[0] <= CMPW'(nsa_q >> QB) >= CMPW'(dva_q);
      ot_q[0] <= CMPW'(nta_q >> QB) >= CMPW'(dva_q);
      dz_q[0] <= (dva_q == '0);
      dv_q[0] <= dva_q;
      qs_q[0] <= '0;
      qt_q[0] <= '0;
      sd_q[0] <= sidea_q;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_step
    logic [DMW:0]   trs, trt;
    logic           ges, get;
    logic [DMW-1:0] nrs, nrt;

    always_comb begin
      trs = {rs_q[j], ls_q[j][QB-1-j]};
      trt = {rt_q[j], lt_q[j][QB-1-j]};
      ges = trs >= {1'b0, dv_q[j]};
      get = trt >= {1'b0, dv_q[j]};
      nrs = ges ? DMW'(trs - {1'b0, dv_q[j]}) : trs[DMW-1:0];
      nrt = get ? DMW'(trt - {1'b0, dv_q[j]}) : trt[DMW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rs_q[j+1] <= nrs;
        rt_q[j+1] <= nrt;
        ls_q[j+1] <= ls_q[j];
        lt_q[j+1] <= lt_q[j];
        qs_q[j+1] <= {qs_q[j][QB-2:0], ges};
        qt_q[j+1] <= {qt_q[j][QB-2:0], get};
        os_q[j+1] <= os_q[j];
        ot_q[j+1] <= ot_q[j];
        dz_q[j+1] <= dz_q[j];
        dv_q[j+1] <= dv_q[j];
        sd_q[j+1] <= sd_q[j];
      end
    end
  end

  assign valid_o = v_q[QB];
  assign qs_o    = qs_q[QB];
  assign qt_o    = qt_q[QB];
  assign ovs_o   = os_q[QB];
  assign ovt_o   = ot_q[QB];
  assign dz_o    = dz_q[QB];
  assign side_o  = sd_q[QB];

endmodule

@@ design/lccp_sqrt.sv @@
// Pipelined integer square root, floor, one root bit per stage.
// Standalone; carries a side payload alongside each item.
module lccp_sqrt #(
  parameter int SQW = 68,
  parameter int RB  = 34,
  parameter int SW  = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [SQW-1:0] sum_i,
  input  logic [SW-1:0]  side_i,
  output logic           valid_o,
  output logic [RB-1:0]  root_o,
  output logic [SW-1:0]  side_o
);

  logic           v_q  [RB+1];
  logic [SQW-1:0] rem_q[RB+1];
  logic [RB-1:0]  rt_q [RB+1];
  logic [SW-1:0]  sd_q [RB+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= sum_i;
      rt_q[0]  <= '0;
      sd_q[0]  <= side_i;
    end
  end

  for (genvar j = 0; j < RB; j++) begin : g_step
    localparam int B = RB - 1 - j;
    logic [SQW:0]   term;
    logic           ge;
    logic [SQW-1:0] nrem;
    logic [RB-1:0]  nrt;

    // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
    always_comb begin
      term = ((SQW+1)'(rt_q[j]) << (B + 1)) + ((SQW+1)'(1) << (2 * B));
      ge   = {1'b0, rem_q[j]} >= term;
      nrem = ge ? SQW'({1'b0, rem_q[j]} - term) : rem_q[j];
      nrt  = rt_q[j];
      nrt[B] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1] <= nrem;
        rt_q[j+1]  <= nrt;
        sd_q[j+1]  <= sd_q[j];
      end
    end
  end

  assign valid_o = v_q[RB];
  assign root_o  = rt_q[RB];
  assign side_o  = sd_q[RB];

endmodule
